### hw/rtl/box_filter_image_downscaler_assert.svh
// Assertion helpers for the box filter downscaler.
// Both sample on clk and are off while rst_n is low.
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_ASSERT_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_ASSERT_SVH

// Condition that must hold at every clock edge
`define BFD_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define BFD_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bfd_pkg.sv
package bfd_pkg;

    localparam int MAX_SOURCE_DIM = 4096;
    localparam int MAX_OUT_SIZE   = 256;

    localparam int DIM_W  = 13;                     // width, height, edges
    localparam int SIZE_W = 9;                      // grid side
    localparam int IDX_W  = $clog2(MAX_OUT_SIZE);   // cell index
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 25;
    localparam int MUL_W  = SIZE_W + DIM_W;         // (cell + 2) * source dimension
    localparam int DIV_W  = 32;

    // One source pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

    // Clamped geometry
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [SIZE_W-1:0] size;
        logic              has_alpha;
    } geom_t;

    // Register map
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SIZE   = 2'd2,
        REG_ALPHA  = 2'd3
    } reg_idx_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

### hw/rtl/bfd_if.sv
// Source pixel channel
interface bfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// Averaged cell channel
interface bfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic       last_cell;

    modport source (output valid, red_out, green_out, blue_out, alpha_out,
                    cell_x, cell_y, last_cell, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                    cell_x, cell_y, last_cell, output ready);
endinterface

### hw/rtl/bfd_cfg.sv
module bfd_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bfd_pkg::geom_t      geom,
    output logic                restart
);

    logic [bfd_pkg::DIM_W-1:0]  width_reg;
    logic [bfd_pkg::DIM_W-1:0]  height_reg;
    logic [bfd_pkg::SIZE_W-1:0] size_reg;
    logic                       alpha_reg;
    logic                       restart_reg;
    logic                       wr_en;
    bfd_pkg::reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = bfd_pkg::reg_idx_t'(paddr[3:2]);

    // Register writes; geometry writes restart the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= bfd_pkg::DIM_W'(64);
            height_reg  <= bfd_pkg::DIM_W'(64);
            size_reg    <= bfd_pkg::SIZE_W'(64);
            alpha_reg   <= 1'b1;
            restart_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (idx)
                    bfd_pkg::REG_WIDTH:
                    begin
                        width_reg   <= pwdata[bfd_pkg::DIM_W-1:0];
                        restart_reg <= 1'b1;
                    end
                    bfd_pkg::REG_HEIGHT:
                    begin
                        height_reg  <= pwdata[bfd_pkg::DIM_W-1:0];
                        restart_reg <= 1'b1;
                    end
                    bfd_pkg::REG_SIZE:
                    begin
                        size_reg    <= pwdata[bfd_pkg::SIZE_W-1:0];
                        restart_reg <= 1'b1;
                    end
                    bfd_pkg::REG_ALPHA:
                    begin
                        alpha_reg   <= pwdata[0];
                    end
                endcase
            end
        end
    end

    // Readback
    always_comb
    begin
        unique case (idx)
            bfd_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            bfd_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            bfd_pkg::REG_SIZE:   prdata = 32'(size_reg);
            bfd_pkg::REG_ALPHA:  prdata = 32'(alpha_reg);
        endcase
    end

    // Clamp geometry into its legal range
    always_comb
    begin
        geom.width  = (width_reg == '0) ? bfd_pkg::DIM_W'(1) :
                      (width_reg > bfd_pkg::DIM_W'(bfd_pkg::MAX_SOURCE_DIM)) ?
                      bfd_pkg::DIM_W'(bfd_pkg::MAX_SOURCE_DIM) : width_reg;
        geom.height = (height_reg == '0) ? bfd_pkg::DIM_W'(1) :
                      (height_reg > bfd_pkg::DIM_W'(bfd_pkg::MAX_SOURCE_DIM)) ?
                      bfd_pkg::DIM_W'(bfd_pkg::MAX_SOURCE_DIM) : height_reg;
        geom.size   = (size_reg == '0) ? bfd_pkg::SIZE_W'(1) :
                      (size_reg > bfd_pkg::SIZE_W'(bfd_pkg::MAX_OUT_SIZE)) ?
                      bfd_pkg::SIZE_W'(bfd_pkg::MAX_OUT_SIZE) : size_reg;
        geom.has_alpha = alpha_reg;
    end

    assign restart = restart_reg;

endmodule

### hw/rtl/bfd_front.sv
module bfd_front
(
    input  logic           clk,
    input  logic           rst_n,
    bfd_in_if.sink         pix_in,
    input  logic           has_alpha,
    output logic           q_valid,
    output bfd_pkg::pix_t  q_data,
    input  logic           q_pop
);

    bfd_pkg::pix_t fifo_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    bfd_pkg::pix_t pix;

    assign pix_in.ready = (count_reg != 2'd2);
    assign push         = pix_in.valid && pix_in.ready;
    assign q_valid      = (count_reg != 2'd0);
    assign q_data       = fifo_reg[rd_ptr_reg];

    // Without alpha every pixel counts as opaque
    always_comb
    begin
        pix.red   = pix_in.red_in;
        pix.green = pix_in.green_in;
        pix.blue  = pix_in.blue_in;
        pix.alpha = has_alpha ? pix_in.alpha_in : 8'd255;
    end

    // Two-entry queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= pix;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### hw/rtl/bfd_div.sv
module bfd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  bfd_pkg::div_req_t req,
    output bfd_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(bfd_pkg::DIV_W);

    logic [bfd_pkg::DIV_W-1:0] rem_reg;
    logic [bfd_pkg::DIV_W-1:0] quo_reg;
    logic [bfd_pkg::DIV_W-1:0] dvs_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [bfd_pkg::DIV_W:0]   shifted;
    logic [bfd_pkg::DIV_W:0]   diff;

    // One restoring step: shift in the next dividend bit, try subtract
    assign shifted = {rem_reg, quo_reg[bfd_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[bfd_pkg::DIV_W])
            begin
                rem_reg <= diff[bfd_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[bfd_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[bfd_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[bfd_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(bfd_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hw/rtl/bfd_back.sv
module bfd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  bfd_pkg::geom_t    geom,
    input  logic              restart,
    input  logic              q_valid,
    input  bfd_pkg::pix_t     q_data,
    output logic              q_pop,
    output bfd_pkg::div_req_t div_req,
    input  bfd_pkg::div_rsp_t div_rsp,
    bfd_out_if.source         cell_out
);

    localparam int DIM_W  = bfd_pkg::DIM_W;
    localparam int SIZE_W = bfd_pkg::SIZE_W;
    localparam int IDX_W  = bfd_pkg::IDX_W;
    localparam int SUM_W  = bfd_pkg::SUM_W;
    localparam int CNT_W  = bfd_pkg::CNT_W;
    localparam int MUL_W  = bfd_pkg::MUL_W;
    localparam int DIV_W  = bfd_pkg::DIV_W;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] alpha;
        logic [CNT_W-1:0] count;
    } acc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POST,
        ST_ADV,
        ST_ROW_INIT,
        ST_COL_INIT,
        ST_EDGE_GO,
        ST_EDGE_WAIT,
        ST_SEEK
    } state_t;

    localparam logic AXIS_COL = 1'b0;
    localparam logic AXIS_ROW = 1'b1;

    // Per-column band sums
    acc_t mem [bfd_pkg::MAX_OUT_SIZE];
    acc_t rd_reg;

    state_t             state_reg;
    logic               pend_reg;
    bfd_pkg::pix_t      pix_reg;
    acc_t               acc_reg;
    logic [DIM_W-1:0]   src_col_reg;
    logic [DIM_W-1:0]   src_row_reg;
    logic [IDX_W-1:0]   cell_col_reg;
    logic [IDX_W-1:0]   cell_row_reg;
    logic [DIM_W-1:0]   col_start_reg;
    logic [DIM_W-1:0]   col_end_reg;
    logic [DIM_W-1:0]   row_end_reg;
    logic               band_first_reg;
    logic               axis_reg;
    logic [DIM_W-1:0]   pos_reg;
    logic [MUL_W-1:0]   mul_reg;
    logic [1:0]         ch_reg;
    logic [7:0]         avg_reg [4];
    logic               out_valid_reg;
    logic [7:0]         out_red_reg;
    logic [7:0]         out_green_reg;
    logic [7:0]         out_blue_reg;
    logic [7:0]         out_alpha_reg;
    logic [7:0]         out_x_reg;
    logic [7:0]         out_y_reg;
    logic               out_last_reg;

    logic               rd_en;
    logic               wr_en;
    logic               first;
    logic               emit;
    acc_t               acc_new;
    logic [DIM_W-1:0]   col_next;
    logic [DIM_W-1:0]   row_next;
    logic [IDX_W-1:0]   seek_cell;
    logic [DIM_W-1:0]   seek_end;
    logic [DIM_W-1:0]   seek_dim;
    logic               seek_more;
    logic [MUL_W-1:0]   seek_mul;
    logic [SUM_W-1:0]   ch_sum;
    logic [7:0]         avg_q;
    logic               out_free;

    assign rd_en    = (state_reg == ST_IDLE) && !pend_reg && q_valid;
    assign q_pop    = rd_en;
    assign wr_en    = (state_reg == ST_ACC);
    assign col_next = src_col_reg + DIM_W'(1);
    assign row_next = src_row_reg + DIM_W'(1);
    assign out_free = !out_valid_reg || cell_out.ready;

    // Start a cell afresh on its first pixel of the band, else accumulate
    always_comb
    begin
        first = band_first_reg && (src_col_reg == col_start_reg);
        emit  = (col_next == col_end_reg) && (row_next == row_end_reg);
        if (first)
        begin
            acc_new.red   = SUM_W'(pix_reg.red);
            acc_new.green = SUM_W'(pix_reg.green);
            acc_new.blue  = SUM_W'(pix_reg.blue);
            acc_new.alpha = SUM_W'(pix_reg.alpha);
            acc_new.count = CNT_W'(1);
        end
        else
        begin
            acc_new.red   = rd_reg.red + SUM_W'(pix_reg.red);
            acc_new.green = rd_reg.green + SUM_W'(pix_reg.green);
            acc_new.blue  = rd_reg.blue + SUM_W'(pix_reg.blue);
            acc_new.alpha = rd_reg.alpha + SUM_W'(pix_reg.alpha);
            acc_new.count = rd_reg.count + CNT_W'(1);
        end
    end

    // Cell seek on the selected axis
    always_comb
    begin
        seek_cell = (axis_reg == AXIS_ROW) ? cell_row_reg : cell_col_reg;
        seek_end  = (axis_reg == AXIS_ROW) ? row_end_reg : col_end_reg;
        seek_dim  = (axis_reg == AXIS_ROW) ? geom.height : geom.width;
        seek_more = ((SIZE_W'(seek_cell) + SIZE_W'(1)) < geom.size) && (seek_end <= pos_reg);
        seek_mul  = MUL_W'(SIZE_W'(seek_cell) + SIZE_W'(2)) * MUL_W'(seek_dim);
    end

    // Channel sum for the shared divider
    always_comb
    begin
        case (ch_reg)
            2'd0:    ch_sum = acc_reg.red;
            2'd1:    ch_sum = acc_reg.green;
            2'd2:    ch_sum = acc_reg.blue;
            default: ch_sum = acc_reg.alpha;
        endcase
        avg_q = (acc_reg.count == '0) ? 8'd0 : div_rsp.quotient[7:0];
    end

    // Divider requests: edges divide by the grid side, averages by the count
    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_GO) || (state_reg == ST_EDGE_GO);
        if (state_reg == ST_EDGE_GO)
        begin
            div_req.dividend = DIV_W'(mul_reg);
            div_req.divisor  = DIV_W'(geom.size);
        end
        else
        begin
            div_req.dividend = ch_sum;
            div_req.divisor  = DIV_W'(acc_reg.count);
        end
    end

    // Sum memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cell_col_reg] <= acc_new;
        end
        if (rd_en)
        begin
            rd_reg <= mem[cell_col_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pix_reg <= q_data;
        end
        if (wr_en)
        begin
            acc_reg <= acc_new;
        end
        if ((state_reg == ST_DIV_WAIT) && div_rsp.done)
        begin
            avg_reg[ch_reg] <= avg_q;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_reg       <= 1'b1;
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            cell_col_reg   <= '0;
            cell_row_reg   <= '0;
            col_start_reg  <= '0;
            col_end_reg    <= '0;
            row_end_reg    <= '0;
            band_first_reg <= 1'b1;
            axis_reg       <= AXIS_COL;
            pos_reg        <= '0;
            mul_reg        <= '0;
            ch_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_red_reg    <= '0;
            out_green_reg  <= '0;
            out_blue_reg   <= '0;
            out_alpha_reg  <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // A restart wins over the pending frame setup being taken
            if (restart)
            begin
                pend_reg <= 1'b1;
            end
            else if ((state_reg == ST_IDLE) && pend_reg)
            begin
                pend_reg <= 1'b0;
            end

            // Output register: load a new cell, else drop after transfer
            if ((state_reg == ST_POST) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cell_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pend_reg)
                    begin
                        state_reg <= ST_ROW_INIT;
                    end
                    else if (q_valid)
                    begin
                        state_reg <= ST_ACC;
                    end
                end

                ST_ACC:
                begin
                    ch_reg    <= '0;
                    state_reg <= emit ? ST_DIV_GO : ST_ADV;
                end

                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end

                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= (ch_reg == 2'd3) ? ST_POST : ST_DIV_GO;
                    end
                end

                ST_POST:
                begin
                    if (out_free)
                    begin
                        out_red_reg   <= avg_reg[0];
                        out_green_reg <= avg_reg[1];
                        out_blue_reg  <= avg_reg[2];
                        out_alpha_reg <= avg_reg[3];
                        out_x_reg     <= 8'(cell_col_reg);
                        out_y_reg     <= 8'(cell_row_reg);
                        out_last_reg  <= ((SIZE_W'(cell_col_reg) + SIZE_W'(1)) == geom.size) &&
                                         ((SIZE_W'(cell_row_reg) + SIZE_W'(1)) == geom.size);
                        state_reg     <= ST_ADV;
                    end
                end

                ST_ADV:
                begin
                    if (col_next >= geom.width)
                    begin
                        if (row_next >= geom.height)
                        begin
                            state_reg <= ST_ROW_INIT;
                        end
                        else
                        begin
                            src_row_reg <= row_next;
                            if (row_next >= row_end_reg)
                            begin
                                band_first_reg <= 1'b1;
                                axis_reg       <= AXIS_ROW;
                                pos_reg        <= row_next;
                                state_reg      <= ST_SEEK;
                            end
                            else
                            begin
                                band_first_reg <= 1'b0;
                                state_reg      <= ST_COL_INIT;
                            end
                        end
                    end
                    else
                    begin
                        src_col_reg <= col_next;
                        if (col_next >= col_end_reg)
                        begin
                            axis_reg  <= AXIS_COL;
                            pos_reg   <= col_next;
                            state_reg <= ST_SEEK;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_ROW_INIT:
                begin
                    src_row_reg    <= '0;
                    cell_row_reg   <= '0;
                    band_first_reg <= 1'b1;
                    mul_reg        <= MUL_W'(geom.height);
                    axis_reg       <= AXIS_ROW;
                    pos_reg        <= '0;
                    state_reg      <= ST_EDGE_GO;
                end

                ST_COL_INIT:
                begin
                    src_col_reg   <= '0;
                    cell_col_reg  <= '0;
                    col_start_reg <= '0;
                    mul_reg       <= MUL_W'(geom.width);
                    axis_reg      <= AXIS_COL;
                    pos_reg       <= '0;
                    state_reg     <= ST_EDGE_GO;
                end

                ST_EDGE_GO:
                begin
                    state_reg <= ST_EDGE_WAIT;
                end

                ST_EDGE_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (axis_reg == AXIS_ROW)
                        begin
                            row_end_reg <= div_rsp.quotient[DIM_W-1:0];
                        end
                        else
                        begin
                            col_end_reg <= div_rsp.quotient[DIM_W-1:0];
                        end
                        state_reg <= ST_SEEK;
                    end
                end

                ST_SEEK:
                begin
                    if (seek_more)
                    begin
                        if (axis_reg == AXIS_ROW)
                        begin
                            cell_row_reg <= cell_row_reg + IDX_W'(1);
                        end
                        else
                        begin
                            cell_col_reg  <= cell_col_reg + IDX_W'(1);
                            col_start_reg <= col_end_reg;
                        end
                        mul_reg   <= seek_mul;
                        state_reg <= ST_EDGE_GO;
                    end
                    else
                    begin
                        state_reg <= (axis_reg == AXIS_ROW) ? ST_COL_INIT : ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cell_out.valid     = out_valid_reg;
    assign cell_out.red_out   = out_red_reg;
    assign cell_out.green_out = out_green_reg;
    assign cell_out.blue_out  = out_blue_reg;
    assign cell_out.alpha_out = out_alpha_reg;
    assign cell_out.cell_x    = out_x_reg;
    assign cell_out.cell_y    = out_y_reg;
    assign cell_out.last_cell = out_last_reg;

endmodule

### hw/rtl/box_filter_image_downscaler.sv
// Pixels: each pixel is popped, accumulated and its position advanced before the next is
// taken; a cell's last pixel adds four 32-step divisions in the shared divider, and each
// cell edge crossed adds a division to compute the next edge in that same divider.
// Reset: control clears asynchronously, then the frame origin is set up (a division
// per edge computed, empty cells included) before pixels leave the input queue.
`include "box_filter_image_downscaler_assert.svh"

module box_filter_image_downscaler
(
    input  logic        clk,
    input  logic        rst_n,
    bfd_in_if.sink      pix_in,
    bfd_out_if.source   cell_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bfd_pkg::geom_t    geom;
    logic              restart;
    logic              q_valid;
    bfd_pkg::pix_t     q_data;
    logic              q_pop;
    bfd_pkg::div_req_t div_req;
    bfd_pkg::div_rsp_t div_rsp;

    bfd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom),
        .restart (restart)
    );

    bfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .has_alpha (geom.has_alpha),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    bfd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bfd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .restart  (restart),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .cell_out (cell_out)
    );

    `BFD_IMPLIES(a_div_idle_on_start, div_req.start, !div_rsp.busy, "divider started while busy")
    `BFD_IMPLIES(a_pop_nonempty, q_pop, q_valid, "pixel queue popped while empty")
    `BFD_IMPLIES(a_last_diag, cell_out.valid && cell_out.last_cell, cell_out.cell_x == cell_out.cell_y, "last cell off the diagonal")
    `BFD_ALWAYS(a_size_range, (geom.size != '0) && (geom.size <= 9'(bfd_pkg::MAX_OUT_SIZE)), "grid side out of range")

endmodule
